// ===== hdl/mct_pkg.sv =====
// ----------------------------------------------------------------------------
// mct_pkg
// Shared types, sizes and codes of the MESI cache tag controller.
// ----------------------------------------------------------------------------
package mct_pkg;

    localparam int NUM_SETS   = 64;
    localparam int NUM_WAYS   = 4;
    localparam int LINE_BYTES = 32;

    localparam int ADDR_W   = 32;
    localparam int OFF_W    = $clog2(LINE_BYTES);
    localparam int SET_BITS = $clog2(NUM_SETS);
    localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int TAG_W    = ADDR_W - OFF_W - SET_BITS;
    localparam int PID_W    = 4;

    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_STORE = 3'd1,
        OP_BUSRD = 3'd2,
        OP_RDX   = 3'd3,
        OP_UPGR  = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_I = 2'd0,
        ST_S = 2'd1,
        ST_E = 2'd2,
        ST_M = 2'd3
    } mesi_t;

    typedef enum logic [1:0] {
        BUS_NONE = 2'd0,
        BUS_RD   = 2'd1,
        BUS_RDX  = 2'd2,
        BUS_UPGR = 2'd3
    } bus_t;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_LOOKUP = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        mesi_t            state;
    } line_t;

    typedef line_t [NUM_WAYS-1:0] row_t;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
        bus_t             bus;
        logic [PID_W-1:0] owner;
        logic             fill;
        mesi_t            new_state;
        logic             wr_through;
        logic             ack;
        logic             flush;
        logic             inval;
    } result_t;

endpackage

// ===== hdl/mct_tag_ram.sv =====
// ----------------------------------------------------------------------------
// mct_tag_ram
// Tag and state memory, one row of all ways per set, registered read.
// ----------------------------------------------------------------------------
module mct_tag_ram
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [mct_pkg::SET_W-1:0]   rd_set,
    output mct_pkg::row_t               rd_row,
    input  logic                        wr_en,
    input  logic [mct_pkg::SET_W-1:0]   wr_set,
    input  mct_pkg::row_t               wr_row
);

    mct_pkg::row_t                  mem [mct_pkg::NUM_SETS];
    logic [mct_pkg::NUM_SETS-1:0]   row_valid_reg;
    mct_pkg::row_t                  rd_data_reg;
    logic                           rd_valid_reg;

    // A row never written since reset reads as all lines invalid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            row_valid_reg[wr_set] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_set] <= wr_row;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_set];
            rd_valid_reg <= row_valid_reg[rd_set];
        end
    end

    always_comb
    begin
        rd_row = rd_data_reg;
        for (int w = 0; w < mct_pkg::NUM_WAYS; w++)
        begin
            if (!rd_valid_reg)
            begin
                rd_row[w].state = mct_pkg::ST_I;
            end
        end
    end

endmodule

// ===== hdl/mct_lookup.sv =====
// ----------------------------------------------------------------------------
// mct_lookup
// Tag compare, victim choice and MESI transition on one row of the store.
// ----------------------------------------------------------------------------
module mct_lookup
(
    input  mct_pkg::opcode_t            opcode,
    input  logic [mct_pkg::TAG_W-1:0]   tag,
    input  logic [mct_pkg::PID_W-1:0]   pid,
    input  mct_pkg::row_t               row,
    output mct_pkg::result_t            result,
    output logic                        row_write,
    output mct_pkg::row_t               new_row
);

    logic                           found;
    logic [mct_pkg::WAY_W-1:0]      hit_way;
    logic                           free;
    logic [mct_pkg::WAY_W-1:0]      victim_way;
    mct_pkg::mesi_t                 cur_state;

    // First matching way, and first invalid way (else way 0) for allocation
    always_comb
    begin
        found      = 1'b0;
        hit_way    = '0;
        free       = 1'b0;
        victim_way = '0;
        for (int w = 0; w < mct_pkg::NUM_WAYS; w++)
        begin
            if (!found && row[w].state != mct_pkg::ST_I && row[w].tag == tag)
            begin
                found   = 1'b1;
                hit_way = mct_pkg::WAY_W'(w);
            end
            if (!free && row[w].state == mct_pkg::ST_I)
            begin
                free       = 1'b1;
                victim_way = mct_pkg::WAY_W'(w);
            end
        end
        cur_state = row[hit_way].state;
    end

    always_comb
    begin
        result    = '0;
        new_row   = row;
        row_write = 1'b0;
        unique case (opcode)
            mct_pkg::OP_LOAD, mct_pkg::OP_STORE:
            begin
                row_write = 1'b1;
                if (found)
                begin
                    result.hit = 1'b1;
                    result.way = hit_way;
                    if (opcode == mct_pkg::OP_STORE)
                    begin
                        if (cur_state == mct_pkg::ST_S || cur_state == mct_pkg::ST_E)
                        begin
                            result.bus = mct_pkg::BUS_UPGR;
                        end
                        new_row[hit_way].state = mct_pkg::ST_M;
                        result.new_state       = mct_pkg::ST_M;
                        result.wr_through      = 1'b1;
                    end
                    else
                    begin
                        result.new_state = cur_state;
                    end
                end
                else
                begin
                    result.way              = victim_way;
                    result.fill             = 1'b1;
                    new_row[victim_way].tag = tag;
                    if (opcode == mct_pkg::OP_LOAD)
                    begin
                        result.bus                = mct_pkg::BUS_RD;
                        new_row[victim_way].state = mct_pkg::ST_E;
                        result.new_state          = mct_pkg::ST_E;
                    end
                    else
                    begin
                        result.bus                = mct_pkg::BUS_RDX;
                        new_row[victim_way].state = mct_pkg::ST_M;
                        result.new_state          = mct_pkg::ST_M;
                        result.wr_through         = 1'b1;
                    end
                end
            end
            mct_pkg::OP_BUSRD, mct_pkg::OP_RDX, mct_pkg::OP_UPGR:
            begin
                if (found)
                begin
                    row_write  = 1'b1;
                    result.hit = 1'b1;
                    result.ack = 1'b1;
                    result.way = hit_way;
                    if (opcode == mct_pkg::OP_BUSRD)
                    begin
                        // Shared copies stay shared; owners drop to shared
                        result.flush           = (cur_state == mct_pkg::ST_M);
                        new_row[hit_way].state = mct_pkg::ST_S;
                        result.new_state       = mct_pkg::ST_S;
                    end
                    else
                    begin
                        new_row[hit_way].state = mct_pkg::ST_I;
                        result.new_state       = mct_pkg::ST_I;
                        result.inval           = 1'b1;
                    end
                end
            end
            default:
            begin
                row_write = 1'b0;
            end
        endcase
        if (result.bus != mct_pkg::BUS_NONE)
        begin
            result.owner = pid;
        end
    end

endmodule

// ===== hdl/mesi_cache_tag_controller.sv =====
// ----------------------------------------------------------------------------
// mesi_cache_tag_controller
// Tag and MESI state controller of a set-associative write-through cache.
// ----------------------------------------------------------------------------
// The edge that accepts start issues the read of the set's row from the
// synchronous tag memory, busy is high for the following lookup cycle,
// and at its end the row is written back and the result is registered.
// The result appears for exactly one cycle with done high, and the receiver
// cannot stall it; start may be accepted again in that same cycle, so a
// new item can enter while the last result is shown. Lines reset to
// invalid through one valid flag per set, cleared at once by reset, so
// there is no clearing pass. processor_id must be written through
// cfg_write and cfg_data only while idle; the block does not check this.
// ----------------------------------------------------------------------------
module mesi_cache_tag_controller
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [mct_pkg::PID_W-1:0]   cfg_data,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  opcode,
    input  logic [mct_pkg::ADDR_W-1:0]  address,
    output logic                        done,
    output logic                        hit,
    output logic [mct_pkg::SET_W-1:0]   set_index,
    output logic [mct_pkg::WAY_W-1:0]   way_index,
    output logic [1:0]                  bus_request,
    output logic [mct_pkg::PID_W-1:0]   request_owner,
    output logic                        line_fill,
    output logic [1:0]                  new_state,
    output logic                        write_through,
    output logic                        snoop_ack,
    output logic                        flush_line,
    output logic                        invalidated
);

    mct_pkg::ctrl_state_t           state_reg, state_next;
    logic                           done_reg;
    logic [mct_pkg::PID_W-1:0]      pid_reg;
    mct_pkg::opcode_t               op_reg;
    logic [mct_pkg::TAG_W-1:0]      tag_reg;
    logic [mct_pkg::SET_W-1:0]      set_reg;
    logic [mct_pkg::SET_W-1:0]      res_set_reg;
    mct_pkg::result_t               res_reg;

    logic                           accept;
    logic                           rd_en;
    logic                           wr_en;
    logic [mct_pkg::SET_W-1:0]      in_set;
    logic [mct_pkg::TAG_W-1:0]      in_tag;
    logic [mct_pkg::ADDR_W-1:0]     line_addr;
    mct_pkg::row_t                  rd_row;
    mct_pkg::row_t                  new_row;
    mct_pkg::result_t               lk_result;
    logic                           lk_write;

    assign line_addr = address >> mct_pkg::OFF_W;
    assign in_set    = mct_pkg::SET_W'(line_addr & mct_pkg::ADDR_W'(mct_pkg::NUM_SETS - 1));
    assign in_tag    = mct_pkg::TAG_W'(address >> (mct_pkg::OFF_W + mct_pkg::SET_BITS));

    mct_tag_ram u_ram
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (rd_en),
        .rd_set (in_set),
        .rd_row (rd_row),
        .wr_en  (wr_en),
        .wr_set (set_reg),
        .wr_row (new_row)
    );

    mct_lookup u_lookup
    (
        .opcode    (op_reg),
        .tag       (tag_reg),
        .pid       (pid_reg),
        .row       (rd_row),
        .result    (lk_result),
        .row_write (lk_write),
        .new_row   (new_row)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mct_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = mct_pkg::S_LOOKUP;
                end
            end
            mct_pkg::S_LOOKUP:
            begin
                state_next = mct_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mct_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy  = 1'b0;
        rd_en = 1'b0;
        wr_en = 1'b0;
        unique case (state_reg)
            mct_pkg::S_IDLE:
            begin
                rd_en = start;
            end
            mct_pkg::S_LOOKUP:
            begin
                busy  = 1'b1;
                wr_en = lk_write;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    assign accept = rd_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mct_pkg::S_IDLE;
            done_reg  <= 1'b0;
            pid_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == mct_pkg::S_LOOKUP);
            if (cfg_write)
            begin
                pid_reg <= cfg_data;
            end
        end
    end

    // Hold the item through lookup; capture the result for the strobe cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= mct_pkg::opcode_t'(opcode);
            tag_reg <= in_tag;
            set_reg <= in_set;
        end
        if (state_reg == mct_pkg::S_LOOKUP)
        begin
            res_reg     <= lk_result;
            res_set_reg <= set_reg;
        end
    end

    assign done          = done_reg;
    assign hit           = res_reg.hit;
    assign set_index     = res_set_reg;
    assign way_index     = res_reg.way;
    assign bus_request   = res_reg.bus;
    assign request_owner = res_reg.owner;
    assign line_fill     = res_reg.fill;
    assign new_state     = res_reg.new_state;
    assign write_through = res_reg.wr_through;
    assign snoop_ack     = res_reg.ack;
    assign flush_line    = res_reg.flush;
    assign invalidated   = res_reg.inval;

endmodule
